// File: rtl/bjtem_pkg.sv
`default_nettype none
package bjtem_pkg;

    localparam logic [63:0] LOG2E_Q30    = 64'd1549082005;
    localparam logic [63:0] LN2_Q30      = 64'd744261118;
    localparam logic [63:0] ONE_Q30      = 64'd1073741824;
    localparam logic signed [29:0] ARG_LIMIT = 30'sd2621440;

    localparam logic [31:0] RST_SAT_CURRENT = 32'd184467;
    localparam logic [23:0] RST_INV_VT      = 24'd2535000;
    localparam logic [16:0] RST_INV_BF      = 17'd328;
    localparam logic [16:0] RST_INV_BR      = 17'd32768;

    typedef enum logic [1:0] {
        CFG_SAT_CURRENT = 2'd0,
        CFG_INV_VT      = 2'd1,
        CFG_INV_BF      = 2'd2,
        CFG_INV_BR      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [23:0] node_voltage_a;
        logic signed [23:0] node_voltage_b;
    } t_item;

    typedef struct packed {
        logic signed [63:0] first_current;
        logic signed [63:0] second_current;
        logic signed [63:0] jac_aa;
        logic signed [63:0] jac_ab;
        logic signed [63:0] jac_ba;
        logic signed [63:0] jac_bb;
    } t_result;

    // Mantissa in Q.30 and power-of-two exponent of one exponential.
    typedef struct packed {
        logic        [31:0] m;
        logic signed [7:0]  n;
    } t_exp;

    // Saturation current, thermal reciprocal and products of the saturation current with the gain coefficients.
    typedef struct packed {
        logic [31:0] is_q;
        logic [23:0] ivt;
        logic [48:0] pf;
        logic [48:0] pr;
        logic [49:0] ps;
        logic [8:0]  one_f;
        logic [8:0]  one_r;
        logic [7:0]  one_p1;
        logic [9:0]  one_ps;
    } t_coef;

    // Saturated magnitudes of the exponential terms.
    typedef struct packed {
        logic [62:0] a;
        logic [62:0] b;
        logic [62:0] e;
        logic [62:0] f;
        logic [62:0] j1;
        logic [62:0] j2;
        logic [62:0] j3;
        logic [62:0] j4;
    } t_terms;

    // Right shift followed by saturation of the magnitude at 2^63-1.
    function automatic logic [62:0] shr_sat(input logic [105:0] p, input logic [7:0] r);
        logic [105:0] s;
        s = p >> r;
        return (|s[105:63]) ? {63{1'b1}} : s[62:0];
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] mag(input logic [62:0] x);
        return $signed({1'b0, x});
    endfunction

endpackage
`default_nettype wire

// File: rtl/bjtem_exp.sv
`default_nettype none
module bjtem_exp import bjtem_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  wire logic               i_clk,
    input  wire logic signed [24:0] i_dv,
    input  wire logic        [23:0] i_ivt,
    output t_exp                    o_exp
);

    localparam int IW = $clog2(DEPTH + 1);
    localparam int PW = 16 + IW;

    logic [31:0] w_tab [0:DEPTH];

    // Each entry of the 2^(k/D) table is a Taylor series of exp(t) to the 16th power, t in Q.30,
    // with every term rounded half up to Q.30.
    for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
        localparam logic [63:0] TabArg = (64'(k) * LN2_Q30 + 64'(DEPTH / 2)) / 64'(DEPTH);
        localparam logic [63:0] Tm01 = (ONE_Q30 * TabArg + (64'd1 << 29)) / (64'd1 << 30);
        localparam logic [63:0] Tm02 = (Tm01 * TabArg + (64'd2 << 29)) / (64'd2 << 30);
        localparam logic [63:0] Tm03 = (Tm02 * TabArg + (64'd3 << 29)) / (64'd3 << 30);
        localparam logic [63:0] Tm04 = (Tm03 * TabArg + (64'd4 << 29)) / (64'd4 << 30);
        localparam logic [63:0] Tm05 = (Tm04 * TabArg + (64'd5 << 29)) / (64'd5 << 30);
        localparam logic [63:0] Tm06 = (Tm05 * TabArg + (64'd6 << 29)) / (64'd6 << 30);
        localparam logic [63:0] Tm07 = (Tm06 * TabArg + (64'd7 << 29)) / (64'd7 << 30);
        localparam logic [63:0] Tm08 = (Tm07 * TabArg + (64'd8 << 29)) / (64'd8 << 30);
        localparam logic [63:0] Tm09 = (Tm08 * TabArg + (64'd9 << 29)) / (64'd9 << 30);
        localparam logic [63:0] Tm10 = (Tm09 * TabArg + (64'd10 << 29)) / (64'd10 << 30);
        localparam logic [63:0] Tm11 = (Tm10 * TabArg + (64'd11 << 29)) / (64'd11 << 30);
        localparam logic [63:0] Tm12 = (Tm11 * TabArg + (64'd12 << 29)) / (64'd12 << 30);
        localparam logic [63:0] Tm13 = (Tm12 * TabArg + (64'd13 << 29)) / (64'd13 << 30);
        localparam logic [63:0] Tm14 = (Tm13 * TabArg + (64'd14 << 29)) / (64'd14 << 30);
        localparam logic [63:0] Tm15 = (Tm14 * TabArg + (64'd15 << 29)) / (64'd15 << 30);
        localparam logic [63:0] Tm16 = (Tm15 * TabArg + (64'd16 << 29)) / (64'd16 << 30);
        localparam logic [63:0] TabSum = ONE_Q30 + Tm01 + Tm02 + Tm03 + Tm04 + Tm05
                                       + Tm06 + Tm07 + Tm08 + Tm09 + Tm10 + Tm11
                                       + Tm12 + Tm13 + Tm14 + Tm15 + Tm16;
        localparam logic [31:0] TabVal = TabSum[31:0];
        assign w_tab[k] = TabVal;
    end

    // Argument scaling by the thermal reciprocal.
    logic signed [49:0] w_prod;
    logic signed [29:0] r_x;
    assign w_prod = i_dv * $signed({1'b0, i_ivt});

    // Clamp and change of base.
    logic signed [22:0] w_xc;
    logic signed [54:0] w_y;
    logic signed [23:0] r_y;
    always_comb begin
        if (r_x > ARG_LIMIT) begin
            w_xc = ARG_LIMIT[22:0];
        end else if (r_x < -ARG_LIMIT) begin
            w_xc = 23'(-ARG_LIMIT);
        end else begin
            w_xc = r_x[22:0];
        end
        w_y = w_xc * $signed({1'b0, LOG2E_Q30[30:0]});
    end

    // Table lookup.
    logic [PW-1:0] w_pos;
    logic [IW-1:0] w_idx;
    logic [IW-1:0] w_idx1;
    logic [31:0]   r_a;
    logic [31:0]   r_b;
    logic [15:0]   r_fr;
    logic signed [7:0] r_n3;
    assign w_pos  = PW'(r_y[15:0]) * PW'(DEPTH);
    assign w_idx  = w_pos[PW-1:16];
    assign w_idx1 = w_idx + IW'(1);

    // Interpolation.
    logic [31:0] w_diff;
    logic [47:0] w_ip;
    logic [31:0] r_m;
    logic signed [7:0] r_n4;
    assign w_diff = r_b - r_a;
    assign w_ip   = 48'(w_diff) * 48'(r_fr);

    always_ff @(posedge i_clk) begin
        r_x  <= w_prod[49:20];
        r_y  <= w_y[53:30];
        r_a  <= w_tab[w_idx];
        r_b  <= w_tab[w_idx1];
        r_fr <= w_pos[15:0];
        r_n3 <= r_y[23:16];
        r_m  <= r_a + w_ip[47:16];
        r_n4 <= r_n3;
    end

    assign o_exp.m = r_m;
    assign o_exp.n = r_n4;

endmodule
`default_nettype wire

// File: rtl/bjtem_prod.sv
`default_nettype none
module bjtem_prod import bjtem_pkg::*; (
    input  wire logic  i_clk,
    input  wire t_exp  i_ef,
    input  wire t_exp  i_er,
    input  wire t_coef i_coef,
    output t_terms     o_terms
);

    // Partial products of the coefficients with the mantissas.
    logic [63:0] r_pff_lo, r_psf_lo, r_prr_lo, r_isr;
    logic [48:0] r_pff_hi, r_prr_hi;
    logic [49:0] r_psf_hi;
    logic [7:0]  r_nf1, r_nr1;

    // Full current products.
    logic [81:0] r_xf, r_xs, r_xr;
    logic [63:0] r_xi;
    logic [7:0]  r_nf2, r_nr2;

    // Current terms and partial products with the thermal reciprocal.
    logic [62:0] r_a3, r_b3, r_e3, r_f3;
    logic [55:0] r_qf0, r_qf1, r_qs0, r_qs1, r_qr0, r_qr1, r_qi0, r_qi1;
    logic [41:0] r_qf2, r_qs2, r_qr2;
    logic [7:0]  r_nf3, r_nr3;

    // Full Jacobian products.
    logic [105:0] r_jf, r_js, r_jr, r_ji;
    logic [62:0]  r_a4, r_b4, r_e4, r_f4;
    logic [7:0]   r_nf4, r_nr4;

    t_terms r_terms;

    logic [7:0] w_rf, w_rr, w_jsf, w_jsr;
    assign w_rf  = 8'd70 - r_nf2;
    assign w_rr  = 8'd70 - r_nr2;
    assign w_jsf = 8'd86 - r_nf4;
    assign w_jsr = 8'd86 - r_nr4;

    always_ff @(posedge i_clk) begin
        r_pff_lo <= 64'(i_coef.pf[31:0]) * 64'(i_ef.m);
        r_pff_hi <= 49'(i_coef.pf[48:32]) * 49'(i_ef.m);
        r_psf_lo <= 64'(i_coef.ps[31:0]) * 64'(i_ef.m);
        r_psf_hi <= 50'(i_coef.ps[49:32]) * 50'(i_ef.m);
        r_prr_lo <= 64'(i_coef.pr[31:0]) * 64'(i_er.m);
        r_prr_hi <= 49'(i_coef.pr[48:32]) * 49'(i_er.m);
        r_isr    <= 64'(i_coef.is_q) * 64'(i_er.m);
        r_nf1    <= i_ef.n;
        r_nr1    <= i_er.n;

        r_xf  <= 82'(r_pff_lo) + (82'(r_pff_hi) << 32);
        r_xs  <= 82'(r_psf_lo) + (82'(r_psf_hi) << 32);
        r_xr  <= 82'(r_prr_lo) + (82'(r_prr_hi) << 32);
        r_xi  <= r_isr;
        r_nf2 <= r_nf1;
        r_nr2 <= r_nr1;

        r_a3  <= shr_sat(106'(r_xf), w_rf);
        r_f3  <= shr_sat(106'(r_xs), w_rf);
        r_b3  <= shr_sat(106'(r_xr), w_rr);
        r_e3  <= shr_sat(106'(r_xi) << 16, w_rr);
        r_qf0 <= 56'(r_xf[31:0])  * 56'(i_coef.ivt);
        r_qf1 <= 56'(r_xf[63:32]) * 56'(i_coef.ivt);
        r_qf2 <= 42'(r_xf[81:64]) * 42'(i_coef.ivt);
        r_qs0 <= 56'(r_xs[31:0])  * 56'(i_coef.ivt);
        r_qs1 <= 56'(r_xs[63:32]) * 56'(i_coef.ivt);
        r_qs2 <= 42'(r_xs[81:64]) * 42'(i_coef.ivt);
        r_qr0 <= 56'(r_xr[31:0])  * 56'(i_coef.ivt);
        r_qr1 <= 56'(r_xr[63:32]) * 56'(i_coef.ivt);
        r_qr2 <= 42'(r_xr[81:64]) * 42'(i_coef.ivt);
        r_qi0 <= 56'(r_xi[31:0])  * 56'(i_coef.ivt);
        r_qi1 <= 56'(r_xi[63:32]) * 56'(i_coef.ivt);
        r_nf3 <= r_nf2;
        r_nr3 <= r_nr2;

        r_jf  <= 106'(r_qf0) + (106'(r_qf1) << 32) + (106'(r_qf2) << 64);
        r_js  <= 106'(r_qs0) + (106'(r_qs1) << 32) + (106'(r_qs2) << 64);
        r_jr  <= 106'(r_qr0) + (106'(r_qr1) << 32) + (106'(r_qr2) << 64);
        r_ji  <= (106'(r_qi0) + (106'(r_qi1) << 32)) << 16;
        r_a4  <= r_a3;
        r_b4  <= r_b3;
        r_e4  <= r_e3;
        r_f4  <= r_f3;
        r_nf4 <= r_nf3;
        r_nr4 <= r_nr3;

        r_terms.a  <= r_a4;
        r_terms.b  <= r_b4;
        r_terms.e  <= r_e4;
        r_terms.f  <= r_f4;
        r_terms.j1 <= shr_sat(r_jf, w_jsf);
        r_terms.j4 <= shr_sat(r_js, w_jsf);
        r_terms.j2 <= shr_sat(r_jr, w_jsr);
        r_terms.j3 <= shr_sat(r_ji, w_jsr);
    end

    assign o_terms = r_terms;

endmodule
`default_nettype wire

// File: rtl/bjtem_sum.sv
`default_nettype none
module bjtem_sum import bjtem_pkg::*; (
    input  wire logic   i_clk,
    input  wire t_terms i_terms,
    input  wire t_coef  i_coef,
    output t_result     o_result
);

    logic signed [63:0] r_f1, r_s1, r_aa1, r_ab1, r_ba1, r_bb1;
    logic signed [63:0] r_f2, r_s2, r_aa2, r_ab2, r_ba2, r_bb2;
    t_result r_res;

    // Saturating sums are taken strictly in order, one addition per stage.
    always_ff @(posedge i_clk) begin
        r_f1  <= sat_add(mag(i_terms.a), mag(i_terms.b));
        r_s1  <= sat_add(mag(i_terms.e), -mag(i_terms.f));
        r_aa1 <= sat_add(-mag(i_terms.j1), -mag(i_terms.j2));
        r_ba1 <= sat_add(-mag(i_terms.j3), mag(i_terms.j4));
        r_ab1 <= mag(i_terms.j1);
        r_bb1 <= -mag(i_terms.j4);

        r_f2  <= sat_add(r_f1, -$signed({55'd0, i_coef.one_f}));
        r_s2  <= sat_add(r_s1, -$signed({56'd0, i_coef.one_p1}));
        r_aa2 <= r_aa1;
        r_ab2 <= r_ab1;
        r_ba2 <= r_ba1;
        r_bb2 <= r_bb1;

        r_res.first_current  <= sat_add(r_f2, -$signed({55'd0, i_coef.one_r}));
        r_res.second_current <= sat_add(r_s2, $signed({54'd0, i_coef.one_ps}));
        r_res.jac_aa         <= r_aa2;
        r_res.jac_ab         <= r_ab2;
        r_res.jac_ba         <= r_ba2;
        r_res.jac_bb         <= r_bb2;
    end

    assign o_result = r_res;

endmodule
`default_nettype wire

// File: rtl/bjt_ebers_moll_eval_unit.sv
`default_nettype none
// The result strobe of an item rises together with its result, after the item has
// passed the exponential, product and sum stages from its start transfer.
// Throughput: one item per cycle while busy is low; busy is the registered reset.
// The rate is set by the fully pipelined exponential, product and sum stages.
// Reset is synchronous and active low: it restores the configuration defaults,
// drops every valid bit in flight and holds busy high while asserted.
module bjt_ebers_moll_eval_unit import bjtem_pkg::*; #(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_item       i_item,
    output logic             o_strobe,
    output t_result          o_result,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // Four exponential stages, five product stages and three summing stages.
    localparam int LAT = 12;

    logic r_busy;
    logic w_accept;
    logic [LAT-1:0] r_vld;

    logic [31:0] r_sat_current;
    logic [23:0] r_inv_vt;
    logic [16:0] r_inv_bf;
    logic [16:0] r_inv_br;

    t_coef r_coef;
    t_exp  w_ef, w_er;
    t_terms w_terms;

    logic signed [24:0] w_dvf, w_dvr;
    logic [48:0] w_pf, w_pr;
    logic [49:0] w_ps;

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;
    assign w_accept    = start && !r_busy;

    // The block never stalls, so busy only covers reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[LAT-2:0], w_accept};
        end
    end

    // Configuration transfers. The user must write only while no item is in flight; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_current <= RST_SAT_CURRENT;
            r_inv_vt      <= RST_INV_VT;
            r_inv_bf      <= RST_INV_BF;
            r_inv_br      <= RST_INV_BR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SAT_CURRENT: r_sat_current <= i_cfg_data;
                CFG_INV_VT:      r_inv_vt      <= i_cfg_data[23:0];
                CFG_INV_BF:      r_inv_bf      <= i_cfg_data[16:0];
                CFG_INV_BR:      r_inv_br      <= i_cfg_data[16:0];
                default:         r_inv_br      <= r_inv_br;
            endcase
        end
    end

    // The coefficient products are refreshed every cycle. An item first passes
    // the exponential stages, so with no write during its flight it sees settled values.
    assign w_pf = 49'(r_sat_current) * 49'(r_inv_bf);
    assign w_pr = 49'(r_sat_current) * 49'(r_inv_br);
    assign w_ps = 50'(r_sat_current) * (50'd65536 + 50'(r_inv_bf));

    always_ff @(posedge i_clk) begin
        r_coef.is_q   <= r_sat_current;
        r_coef.ivt    <= r_inv_vt;
        r_coef.pf     <= w_pf;
        r_coef.pr     <= w_pr;
        r_coef.ps     <= w_ps;
        r_coef.one_f  <= w_pf[48:40];
        r_coef.one_r  <= w_pr[48:40];
        r_coef.one_p1 <= r_sat_current[31:24];
        r_coef.one_ps <= w_ps[49:40];
    end

    // Forward exponent uses vb - va, reverse exponent uses -va.
    assign w_dvf = {i_item.node_voltage_b[23], i_item.node_voltage_b}
                 - {i_item.node_voltage_a[23], i_item.node_voltage_a};
    assign w_dvr = -{i_item.node_voltage_a[23], i_item.node_voltage_a};

    bjtem_exp #(.DEPTH(EXP_TABLE_DEPTH)) u_exp_f (
        .i_clk (i_clk),
        .i_dv  (w_dvf),
        .i_ivt (r_inv_vt),
        .o_exp (w_ef)
    );

    bjtem_exp #(.DEPTH(EXP_TABLE_DEPTH)) u_exp_r (
        .i_clk (i_clk),
        .i_dv  (w_dvr),
        .i_ivt (r_inv_vt),
        .o_exp (w_er)
    );

    bjtem_prod u_prod (
        .i_clk   (i_clk),
        .i_ef    (w_ef),
        .i_er    (w_er),
        .i_coef  (r_coef),
        .o_terms (w_terms)
    );

    bjtem_sum u_sum (
        .i_clk    (i_clk),
        .i_terms  (w_terms),
        .i_coef   (r_coef),
        .o_result (o_result)
    );

    assign o_strobe = r_vld[LAT-1];

`ifndef NO_ASSERTIONS
    a_strobe_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching start transfer");

    a_jab_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !o_result.jac_ab[63])
        else $error("jac_ab negative");

    a_jbb_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.jac_bb[63] || o_result.jac_bb == 64'sd0))
        else $error("jac_bb positive");
`endif

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
module testbench;
    import bjtem_pkg::*;

    // The table depth must match the parameter that the unit is built with.
    localparam int     DEPTH       = 256;
    localparam longint LOG2E       = 64'sd1549082005;
    localparam longint LN2         = 64'sd744261118;
    localparam longint CLAMP       = 64'sd2621440;
    localparam int     SETTLE      = 16;
    localparam int     ERROR_PRINT = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_strobe;
    t_result     o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    bjt_ebers_moll_eval_unit #(.EXP_TABLE_DEPTH(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Our own copy of the transistor parameters, updated on each register transfer.
    logic [31:0] model_is;
    logic [23:0] model_inv_vt;
    logic [16:0] model_inv_bf;
    logic [16:0] model_inv_br;

    // 2^(k/DEPTH) in Q.30, k = 0..DEPTH.
    logic [31:0] pow2_lut [0:DEPTH];

    t_result expected_results [$];
    int      error_count;
    bit      no_idle;

    always #5 i_clk = ~i_clk;

    // The table is built from a Taylor series of exp(k*ln2/DEPTH) to the 16th power,
    // each term rounded half up, exactly as the hardware constant is derived.
    function automatic void build_pow2_lut();
        logic [63:0] t, sum, term, d;
        for (int k = 0; k <= DEPTH; k++) begin
            t    = (64'(k) * LN2 + DEPTH / 2) / DEPTH;
            sum  = ONE_Q30;
            term = ONE_Q30;
            for (int i = 1; i <= 16; i++) begin
                d    = 64'(i) << 30;
                term = (term * t + d / 2) / d;
                sum  = sum + term;
            end
            pow2_lut[k] = sum[31:0];
        end
    endfunction

    // exp(x) for a Q.16 argument, as a Q.30 mantissa and a power-of-two exponent.
    // The argument is clamped to +/-40 first.
    function automatic void fixed_exp(input longint x, output logic [63:0] m, output int n);
        longint y, nn, f, pos, idx, fr, lo, hi;
        if (x > CLAMP) x = CLAMP;
        if (x < -CLAMP) x = -CLAMP;
        y   = (x * LOG2E) >>> 30;
        nn  = y >>> 16;
        f   = y - nn * 65536;
        pos = f * DEPTH;
        idx = pos >>> 16;
        fr  = pos & 64'hFFFF;
        lo  = longint'({32'd0, pow2_lut[idx]});
        hi  = longint'({32'd0, pow2_lut[idx + 1]});
        m   = 64'(lo + (((hi - lo) * fr) >>> 16));
        n   = int'(nn);
    endfunction

    // floor(a*b / 2^r) with the magnitude saturated at 2^63-1.
    function automatic longint scaled_mag(input logic [63:0] a, input logic [63:0] b,
                                          input int r);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (r < 0) r = 0;
        if (r >= 128) return 0;
        p = p >> r;
        if (p > 128'h7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        return longint'(p[63:0]);
    endfunction

    function automatic longint add_clip(input longint a, input longint b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return longint'(s[63:0]);
    endfunction

    // Branch currents and Jacobian for one pair of node voltages.
    function automatic t_result eval_transistor(input t_item it);
        longint      va, vb, ivt, acc;
        logic [63:0] mf, mr, pf, pr, ps, p1, qf, qr;
        int          nf, nr;
        t_result     r;
        va  = longint'(it.node_voltage_a);
        vb  = longint'(it.node_voltage_b);
        ivt = longint'({40'd0, model_inv_vt});
        fixed_exp(((vb - va) * ivt) >>> 20, mf, nf);
        fixed_exp((-va * ivt) >>> 20, mr, nr);
        pf = 64'(model_is) * 64'(model_inv_bf);
        pr = 64'(model_is) * 64'(model_inv_br);
        ps = 64'(model_is) * (64'd65536 + 64'(model_inv_bf));
        p1 = 64'(model_is) * 64'd65536;
        qf = mf * 64'(model_inv_vt);
        qr = mr * 64'(model_inv_vt);

        acc = scaled_mag(pf, mf, 70 - nf);
        acc = add_clip(acc, scaled_mag(pr, mr, 70 - nr));
        acc = add_clip(acc, -scaled_mag(pf, ONE_Q30, 70));
        acc = add_clip(acc, -scaled_mag(pr, ONE_Q30, 70));
        r.first_current = acc;

        acc = scaled_mag(p1, mr, 70 - nr);
        acc = add_clip(acc, -scaled_mag(ps, mf, 70 - nf));
        acc = add_clip(acc, -scaled_mag(p1, ONE_Q30, 70));
        acc = add_clip(acc, scaled_mag(ps, ONE_Q30, 70));
        r.second_current = acc;

        acc = -scaled_mag(pf, qf, 86 - nf);
        r.jac_aa = add_clip(acc, -scaled_mag(pr, qr, 86 - nr));
        r.jac_ab = scaled_mag(pf, qf, 86 - nf);
        acc = -scaled_mag(p1, qr, 86 - nr);
        r.jac_ba = add_clip(acc, scaled_mag(ps, qf, 86 - nf));
        r.jac_bb = -scaled_mag(ps, qf, 86 - nf);
        return r;
    endfunction

    // Each strobed result is compared with the oldest outstanding expectation.
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= ERROR_PRINT)
                $display("Mismatch on %s: expected %0d, got %0d",
                         name, $signed(want), $signed(got));
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= ERROR_PRINT)
                    $display("Result strobe with no transfer outstanding");
            end else begin
                want = expected_results.pop_front();
                check_field("first_current",  want.first_current,  o_result.first_current);
                check_field("second_current", want.second_current, o_result.second_current);
                check_field("jac_aa", want.jac_aa, o_result.jac_aa);
                check_field("jac_ab", want.jac_ab, o_result.jac_ab);
                check_field("jac_ba", want.jac_ba, o_result.jac_ba);
                check_field("jac_bb", want.jac_bb, o_result.jac_bb);
            end
        end
    end

    // Drives one item and holds it until the start transfer completes. Start is left
    // high so that back-to-back items stream one per cycle. Unless no_idle is set, each
    // cycle idles with a chance of about one in five.
    task automatic send_item(input logic signed [23:0] va, input logic signed [23:0] vb);
        t_item it;
        it.node_voltage_a = va;
        it.node_voltage_b = vb;
        while (!no_idle && $urandom_range(99) < 19) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start  = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(eval_transistor(it));
    endtask

    // Lowers start and waits until every expected result has been checked, then lets
    // the pipeline run empty.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SAT_CURRENT: model_is     = value;
            CFG_INV_VT:      model_inv_vt = value[23:0];
            CFG_INV_BF:      model_inv_bf = value[16:0];
            CFG_INV_BR:      model_inv_br = value[16:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_params(input logic [31:0] is_v, input logic [23:0] vt_v,
                              input logic [16:0] bf_v, input logic [16:0] br_v);
        drain();
        write_reg(CFG_SAT_CURRENT, is_v);
        write_reg(CFG_INV_VT, {8'd0, vt_v});
        write_reg(CFG_INV_BF, {15'd0, bf_v});
        write_reg(CFG_INV_BR, {15'd0, br_v});
    endtask

    // Voltages mostly within about a volt, otherwise anywhere in the signed 24-bit range.
    function automatic logic signed [23:0] rand_volt();
        if ($urandom_range(9) < 3) return 24'($urandom);
        return 24'(int'($urandom_range(2621440)) - 1310720);
    endfunction

    // Field extremes and the clamp boundaries, under the reset parameters.
    task automatic test_directed();
        logic signed [23:0] corner [6];
        corner = '{24'sd0, 24'sh7FFFFF, -24'sh800000, 24'sd1, -24'sd1, 24'sd700000};
        foreach (corner[i])
            foreach (corner[j])
                if ((i + j) % 2 == 0 || i == j) send_item(corner[i], corner[j]);
        // Base-emitter forward bias near 0.7 V and arguments just below the +40 clamp.
        send_item(24'sd0, 24'sd734003);
        send_item(-24'sd1083000, 24'sd0);
        send_item(-24'sd1084000, 24'sd0);
    endtask

    // Extreme and unusual parameter settings: zero thermal reciprocal, zero and
    // full-scale saturation current, inverse gains at zero, unity and above one.
    task automatic test_parameter_extremes();
        logic [31:0] is_set [4];
        logic [23:0] vt_set [4];
        logic [16:0] bf_set [4];
        logic [16:0] br_set [4];
        is_set = '{32'd184467, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF};
        vt_set = '{24'd0, 24'hFFFFFF, 24'd2535000, 24'd1};
        bf_set = '{17'd65536, 17'd0, 17'h1FFFF, 17'd65535};
        br_set = '{17'd0, 17'h1FFFF, 17'd65536, 17'd1};
        for (int s = 0; s < 4; s++) begin
            set_params(is_set[s], vt_set[s], bf_set[s], br_set[s]);
            for (int i = 0; i < 12; i++) send_item(rand_volt(), rand_volt());
        end
    endtask

    // Random items across several random parameter sets. Some sets use realistic
    // values so that the currents stay out of saturation.
    task automatic test_random();
        for (int phase = 0; phase < 7; phase++) begin
            if (phase % 2 == 0)
                set_params($urandom_range(4000000), 24'($urandom_range(1500000, 3000000)),
                           17'($urandom_range(2000)), 17'($urandom_range(65536)));
            else
                set_params($urandom, 24'($urandom), 17'($urandom), 17'($urandom));
            // One phase runs without any idle cycles on the sender side.
            no_idle = (phase == 3);
            for (int i = 0; i < 130; i++) begin
                send_item(rand_volt(), rand_volt());
                // Once, midway through the second phase, the sender waits for every result before going on.
                if (i == 65 && phase == 1) drain();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SAT_CURRENT;
        i_cfg_data  = '0;
        error_count = 0;
        no_idle     = 1'b0;
        model_is     = RST_SAT_CURRENT;
        model_inv_vt = RST_INV_VT;
        model_inv_bf = RST_INV_BF;
        model_inv_br = RST_INV_BR;
        build_pow2_lut();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_parameter_extremes();
        test_random();
        drain();

        if (error_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    // Around a thousand items with short gaps finish well within this time limit.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
